### hw/rtl/icer_pkg.sv
// Shared constants and control types for the input change event recorder.
`default_nettype none

package icer_pkg;

    localparam int VECTOR_BITS = 64;
    localparam int IDX_W       = $clog2(VECTOR_BITS);
    localparam int RAW_BITS    = 64;
    localparam int WORD_W      = 16;
    localparam int TIME_W      = 32;
    localparam int KEY_W       = 33;
    localparam int BIT_INDEX_W = 6;

    localparam int OFFSET_MID       = 16;
    localparam int OFFSET_EXPANSION = 23;
    localparam int OFFSET_REMOTE    = 39;

    typedef struct packed {
        logic load;
        logic skip;
        logic take_on;
        logic take_off;
        logic retire;
    } icer_cmd_t;

    typedef struct packed {
        logic none_left;
        logic changed;
        logic rising;
        logic final_evt;
    } icer_status_t;

endpackage

`default_nettype wire

### hw/rtl/icer_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`default_nettype none

module icer_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/icer_dp.sv
// Datapath: input vector, change mask, bit scan counter, key store and output registers.
`default_nettype none

module icer_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire icer_pkg::icer_cmd_t                 cmd,
    output icer_pkg::icer_status_t                   status,
    input  wire logic [icer_pkg::WORD_W-1:0]         word_low,
    input  wire logic [icer_pkg::WORD_W-1:0]         word_mid,
    input  wire logic [icer_pkg::WORD_W-1:0]         word_expansion,
    input  wire logic [icer_pkg::WORD_W-1:0]         word_remote,
    input  wire logic [icer_pkg::TIME_W-1:0]         now_seconds,
    output logic      [icer_pkg::BIT_INDEX_W-1:0]    bit_index,
    output logic                                     turned_on,
    output logic      [icer_pkg::KEY_W-1:0]          event_key,
    output logic                                     last_event
);
    import icer_pkg::*;

    logic [VECTOR_BITS-1:0] prev_reg;
    logic [VECTOR_BITS-1:0] diff_reg;
    logic [TIME_W-1:0]      now_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [BIT_INDEX_W-1:0] out_idx_reg;
    logic                   out_on_reg;
    logic [KEY_W-1:0]       out_key_reg;
    logic                   out_last_reg;

    logic [RAW_BITS-1:0]    raw_vec;
    logic [VECTOR_BITS-1:0] new_vec;
    logic [VECTOR_BITS-1:0] diff_rest;
    logic                   rest_empty;
    logic [KEY_W-1:0]       on_key;
    logic [KEY_W-1:0]       ram_rdata;

    always_comb
    begin
        raw_vec = RAW_BITS'(word_low)
                | (RAW_BITS'(word_mid) << OFFSET_MID)
                | (RAW_BITS'(word_expansion) << OFFSET_EXPANSION)
                | (RAW_BITS'(word_remote) << OFFSET_REMOTE);
        new_vec = raw_vec[VECTOR_BITS-1:0];
        diff_rest = diff_reg;
        diff_rest[idx_reg] = 1'b0;
        rest_empty = (diff_rest == '0);
        on_key = KEY_W'(now_reg) + KEY_W'(idx_reg);
    end

    icer_ram #(
        .WIDTH(KEY_W),
        .DEPTH(VECTOR_BITS)
    ) u_key_ram (
        .clk   (clk),
        .we    (cmd.take_on),
        .waddr (idx_reg),
        .wdata (on_key),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            diff_reg <= '0;
            idx_reg  <= '0;
        end
        else if (cmd.load)
        begin
            prev_reg <= new_vec;
            diff_reg <= new_vec ^ prev_reg;
            idx_reg  <= '0;
        end
        else if (cmd.skip)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
        else if (cmd.retire)
        begin
            diff_reg <= diff_rest;
            idx_reg  <= idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg <= now_seconds;
        end
        if (cmd.take_on)
        begin
            out_idx_reg  <= BIT_INDEX_W'(idx_reg);
            out_on_reg   <= 1'b1;
            out_key_reg  <= on_key;
            out_last_reg <= rest_empty;
        end
        else if (cmd.take_off)
        begin
            out_idx_reg  <= BIT_INDEX_W'(idx_reg);
            out_on_reg   <= 1'b0;
            out_key_reg  <= ram_rdata;
            out_last_reg <= rest_empty;
        end
    end

    assign status.none_left = (diff_reg == '0);
    assign status.changed   = diff_reg[idx_reg];
    assign status.rising    = prev_reg[idx_reg];
    assign status.final_evt = out_last_reg;

    assign bit_index  = out_idx_reg;
    assign turned_on  = out_on_reg;
    assign event_key  = out_key_reg;
    assign last_event = out_last_reg;

endmodule

`default_nettype wire

### hw/rtl/icer_ctrl.sv
// Controller: snapshot accept, bit scan sequencing and output handshake.
`default_nettype none

module icer_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output icer_pkg::icer_cmd_t         cmd,
    input  wire icer_pkg::icer_status_t status
);
    import icer_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic   in_stall_reg;
    logic   out_valid_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.load     = (state_reg == ST_IDLE) && in_valid;
        cmd.skip     = (state_reg == ST_SCAN) && !status.none_left && !status.changed;
        cmd.take_on  = (state_reg == ST_SCAN) && status.changed && status.rising;
        cmd.take_off = (state_reg == ST_READ);
        cmd.retire   = (state_reg == ST_OUT) && !out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_stall_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg    <= ST_SCAN;
                        in_stall_reg <= 1'b1;
                    end
                end
                ST_SCAN:
                begin
                    if (status.none_left)
                    begin
                        state_reg    <= ST_IDLE;
                        in_stall_reg <= 1'b0;
                    end
                    else if (status.changed && status.rising)
                    begin
                        state_reg     <= ST_OUT;
                        out_valid_reg <= 1'b1;
                    end
                    else if (status.changed)
                    begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    state_reg     <= ST_OUT;
                    out_valid_reg <= 1'b1;
                end
                ST_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        if (status.final_evt)
                        begin
                            state_reg    <= ST_IDLE;
                            in_stall_reg <= 1'b0;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                default:
                begin
                    state_reg     <= ST_IDLE;
                    in_stall_reg  <= 1'b0;
                    out_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    assign in_stall  = in_stall_reg;
    assign out_valid = out_valid_reg;

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall_reg |-> state_reg == ST_IDLE)
        else $error("input ready outside idle");

    a_valid_only_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == ST_OUT) && in_stall_reg)
        else $error("output valid outside output state");

    a_read_then_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |=> (state_reg == ST_OUT) && out_valid_reg)
        else $error("key read not followed by output");

    a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && !status.none_left |=> in_stall_reg)
        else $error("input accepted while bits remain");

endmodule

`default_nettype wire

### hw/rtl/input_change_event_recorder.sv
// Top level of the input change event recorder.
// Input channel (in_valid / in_stall): one snapshot of four 16-bit input words and the
// time in seconds. The words are ORed into one 64-bit vector at bits 0, 16, 23 and 39
// and compared with the previous snapshot.
// Output channel (out_valid / out_stall): one transaction per changed bit, ascending,
// with bit index, direction and event key; last_event marks the final one of a snapshot.
// A turn-on records time plus index as that bit's key; a turn-off returns the stored key.
// Sequence: a snapshot is taken, then a scan counter walks the vector one bit a cycle,
// while no event is pending, up to the highest changed bit. A turn-on event goes
// straight to output; a turn-off event first reads its stored key from the key memory.
// in_stall is high from acceptance until the last event transaction completes or none is found.
// When the receiver stalls, the pending event holds and the scan waits.
// Reset clears the previous vector to zero and returns to idle; the key memory is not
// cleared, since a key is always written before it can be read.
`default_nettype none

module input_change_event_recorder (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [icer_pkg::WORD_W-1:0]         word_low,
    input  wire logic [icer_pkg::WORD_W-1:0]         word_mid,
    input  wire logic [icer_pkg::WORD_W-1:0]         word_expansion,
    input  wire logic [icer_pkg::WORD_W-1:0]         word_remote,
    input  wire logic [icer_pkg::TIME_W-1:0]         now_seconds,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic      [icer_pkg::BIT_INDEX_W-1:0]    bit_index,
    output logic                                     turned_on,
    output logic      [icer_pkg::KEY_W-1:0]          event_key,
    output logic                                     last_event
);
    import icer_pkg::*;

    icer_cmd_t    cmd;
    icer_status_t status;

    icer_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    icer_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .word_low       (word_low),
        .word_mid       (word_mid),
        .word_expansion (word_expansion),
        .word_remote    (word_remote),
        .now_seconds    (now_seconds),
        .bit_index      (bit_index),
        .turned_on      (turned_on),
        .event_key      (event_key),
        .last_event     (last_event)
    );

endmodule

`default_nettype wire
